FILE: hw/rtl/pgr_pkg.sv
// Package for the pointer gesture recognizer.
// Widths, codes, event and config types, saturating timer add.
// No dependencies.
package pgr_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int TIME_WIDTH  = 16;
  localparam int THR_WIDTH   = 12;
  localparam int CFG_WIDTH   = (TIME_WIDTH > THR_WIDTH) ? TIME_WIDTH : THR_WIDTH;
  localparam int CFG_IDX_W   = 3;
  localparam int DIST_WIDTH  = (2 * COORD_WIDTH + 1 > 2 * THR_WIDTH) ?
                               2 * COORD_WIDTH + 1 : 2 * THR_WIDTH;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic [TIME_WIDTH-1:0]         tick_t;
  typedef logic [TIME_WIDTH:0]           timer_t;
  typedef logic [THR_WIDTH-1:0]          thr_t;
  typedef logic [DIST_WIDTH-1:0]         dist_t;
  typedef logic [CFG_WIDTH-1:0]          cfg_data_t;

  typedef enum logic [1:0] {
    OP_PRESS   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_MOVE    = 2'd2,
    OP_TICK    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    G_CLICK      = 3'd0,
    G_DOUBLE     = 3'd1,
    G_LONG_PRESS = 3'd2,
    G_DRAG_START = 3'd3,
    G_DRAG_MOVE  = 3'd4,
    G_DRAG_END   = 3'd5
  } gesture_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DC_WINDOW = 3'd0,
    CFG_LP_TIME   = 3'd1,
    CFG_DRAG_DIST = 3'd2,
    CFG_DC_RADIUS = 3'd3,
    CFG_DC_ON     = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    tick_t dc_window;
    tick_t lp_time;
    thr_t  drag_dist;
    thr_t  dc_radius;
    logic  dc_on;
  } cfg_t;

  typedef struct packed {
    logic [1:0] op;
    coord_t     pos_x;
    coord_t     pos_y;
    tick_t      tick_amount;
  } item_t;

  typedef struct packed {
    gesture_t gesture;
    coord_t   at_x;
    coord_t   at_y;
  } event_t;

  // results of one item, compacted: r0 first, r1 only when two is set
  typedef struct packed {
    logic   any;
    logic   two;
    event_t r0;
    event_t r1;
  } res_pair_t;

  function automatic timer_t sat_add(timer_t a, tick_t b);
    logic [TIME_WIDTH+1:0] s;
    s = {1'b0, a} + {2'b00, b};
    return s[TIME_WIDTH+1] ? {(TIME_WIDTH+1){1'b1}} : s[TIME_WIDTH:0];
  endfunction

endpackage

FILE: hw/rtl/pgr_item_if.sv
// Input channel: pointer and tick items with valid/ready.
// Depends on pgr_pkg.
interface pgr_item_if import pgr_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] op;
  coord_t     pos_x;
  coord_t     pos_y;
  tick_t      tick_amount;

  modport source (output valid, op, pos_x, pos_y, tick_amount, input ready);
  modport sink   (input valid, op, pos_x, pos_y, tick_amount, output ready);
endinterface

FILE: hw/rtl/pgr_event_if.sv
// Output channel: gesture events with valid/ready.
// Depends on pgr_pkg.
interface pgr_event_if import pgr_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [2:0] gesture;
  coord_t     at_x;
  coord_t     at_y;
  logic       final_res;

  modport source (output valid, gesture, at_x, at_y, final_res, input ready);
  modport sink   (input valid, gesture, at_x, at_y, final_res, output ready);
endinterface

FILE: hw/rtl/pgr_cfg.sv
// Configuration registers of the gesture recognizer.
// Depends on pgr_pkg.
module pgr_cfg import pgr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  cfg_data_t            cfg_data,
  output cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dc_window <= TIME_WIDTH'(300);
      cfg.lp_time   <= TIME_WIDTH'(500);
      cfg.drag_dist <= THR_WIDTH'(8);
      cfg.dc_radius <= THR_WIDTH'(4);
      cfg.dc_on     <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DC_WINDOW: cfg.dc_window <= cfg_data[TIME_WIDTH-1:0];
        CFG_LP_TIME:   cfg.lp_time   <= cfg_data[TIME_WIDTH-1:0];
        CFG_DRAG_DIST: cfg.drag_dist <= cfg_data[THR_WIDTH-1:0];
        CFG_DC_RADIUS: cfg.dc_radius <= cfg_data[THR_WIDTH-1:0];
        CFG_DC_ON:     cfg.dc_on     <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

FILE: hw/rtl/pgr_engine.sv
// Gesture state and single-pass step logic for one item.
// Depends on pgr_pkg.
module pgr_engine import pgr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      fire,
  input  item_t     item,
  input  cfg_t      cfg,
  output res_pair_t pair
);

  logic   button_down, drag_active, long_press_fired, click_pending;
  coord_t press_x, press_y, pending_x, pending_y;
  timer_t held_time, pending_time;

  logic   button_down_next, drag_active_next, long_press_fired_next, click_pending_next;
  coord_t press_x_next, press_y_next, pending_x_next, pending_y_next;
  timer_t held_time_next, pending_time_next;

  op_t    op;
  coord_t ref_x, ref_y;
  logic signed [COORD_WIDTH:0] dx, dy;
  logic [COORD_WIDTH-1:0] ax, ay;
  dist_t  d2, drag_sq, radius_sq;
  timer_t held_sum, pend_sum;
  logic   a_v, b_v, start, cp_mid;
  event_t a, b;

  assign op = op_t'(item.op);

  // one distance unit, shared: release measures against the pending click
  assign ref_x = (op == OP_RELEASE) ? pending_x : press_x;
  assign ref_y = (op == OP_RELEASE) ? pending_y : press_y;
  assign dx = {item.pos_x[COORD_WIDTH-1], item.pos_x} - {ref_x[COORD_WIDTH-1], ref_x};
  assign dy = {item.pos_y[COORD_WIDTH-1], item.pos_y} - {ref_y[COORD_WIDTH-1], ref_y};
  assign ax = dx[COORD_WIDTH] ? COORD_WIDTH'(-dx) : dx[COORD_WIDTH-1:0];
  assign ay = dy[COORD_WIDTH] ? COORD_WIDTH'(-dy) : dy[COORD_WIDTH-1:0];
  assign d2 = DIST_WIDTH'(ax * ax) + DIST_WIDTH'(ay * ay);

  assign drag_sq   = DIST_WIDTH'(cfg.drag_dist * cfg.drag_dist);
  assign radius_sq = DIST_WIDTH'(cfg.dc_radius * cfg.dc_radius);

  assign held_sum = sat_add(held_time, item.tick_amount);
  assign pend_sum = sat_add(pending_time, item.tick_amount);

  always_comb begin
    button_down_next      = button_down;
    drag_active_next      = drag_active;
    long_press_fired_next = long_press_fired;
    click_pending_next    = click_pending;
    press_x_next          = press_x;
    press_y_next          = press_y;
    pending_x_next        = pending_x;
    pending_y_next        = pending_y;
    held_time_next        = held_time;
    pending_time_next     = pending_time;
    a_v    = 1'b0;
    b_v    = 1'b0;
    a      = '{G_CLICK, item.pos_x, item.pos_y};
    b      = '{G_CLICK, item.pos_x, item.pos_y};
    start  = 1'b0;
    cp_mid = click_pending;
    unique case (op)
      OP_PRESS: begin
        press_x_next          = item.pos_x;
        press_y_next          = item.pos_y;
        button_down_next      = 1'b1;
        long_press_fired_next = 1'b0;
        held_time_next        = '0;
      end
      OP_RELEASE: begin
        if (drag_active) begin
          a_v = 1'b1;
          a   = '{G_DRAG_END, item.pos_x, item.pos_y};
        end
        drag_active_next = 1'b0;
        button_down_next = 1'b0;
        priority if (drag_active || long_press_fired) begin
          click_pending_next = 1'b0;
        end else if (click_pending && pending_time <= {1'b0, cfg.dc_window} &&
                     d2 <= radius_sq) begin
          click_pending_next = 1'b0;
          b_v = 1'b1;
          b   = '{G_DOUBLE, item.pos_x, item.pos_y};
        end else if (cfg.dc_on) begin
          b_v = click_pending;
          b   = '{G_CLICK, pending_x, pending_y};
          click_pending_next = 1'b1;
          pending_x_next     = item.pos_x;
          pending_y_next     = item.pos_y;
          pending_time_next  = '0;
        end else begin
          b_v = 1'b1;
        end
      end
      OP_MOVE: begin
        if (button_down) begin
          start = !drag_active && d2 >= drag_sq;
          if (start) begin
            drag_active_next   = 1'b1;
            click_pending_next = 1'b0;
            a_v = 1'b1;
            a   = '{G_DRAG_START, press_x, press_y};
          end
          if (drag_active || start) begin
            b_v = 1'b1;
            b   = '{G_DRAG_MOVE, item.pos_x, item.pos_y};
          end
        end
      end
      OP_TICK: begin
        if (button_down && !drag_active && !long_press_fired) begin
          held_time_next = held_sum;
          if (held_sum >= {1'b0, cfg.lp_time}) begin
            long_press_fired_next = 1'b1;
            cp_mid = 1'b0;
            a_v = 1'b1;
            a   = '{G_LONG_PRESS, press_x, press_y};
          end
        end
        click_pending_next = cp_mid;
        if (cp_mid) begin
          pending_time_next = pend_sum;
          if (pend_sum > {1'b0, cfg.dc_window}) begin
            click_pending_next = 1'b0;
            b_v = 1'b1;
            b   = '{G_CLICK, pending_x, pending_y};
          end
        end
      end
    endcase
  end

  always_comb begin
    pair.any = a_v || b_v;
    pair.two = a_v && b_v;
    pair.r0  = a_v ? a : b;
    pair.r1  = b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      button_down      <= 1'b0;
      drag_active      <= 1'b0;
      long_press_fired <= 1'b0;
      click_pending    <= 1'b0;
      press_x          <= '0;
      press_y          <= '0;
      pending_x        <= '0;
      pending_y        <= '0;
      held_time        <= '0;
      pending_time     <= '0;
    end else if (fire) begin
      button_down      <= button_down_next;
      drag_active      <= drag_active_next;
      long_press_fired <= long_press_fired_next;
      click_pending    <= click_pending_next;
      press_x          <= press_x_next;
      press_y          <= press_y_next;
      pending_x        <= pending_x_next;
      pending_y        <= pending_y_next;
      held_time        <= held_time_next;
      pending_time     <= pending_time_next;
    end
  end

endmodule

FILE: hw/rtl/pgr_out.sv
// Result buffer: holds the one or two events of an item and sends them
// one beat at a time. Depends on pgr_pkg and pgr_event_if.
module pgr_out import pgr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  res_pair_t          pair,
  output logic               free,
  pgr_event_if.source        events
);

  logic   pvalid, idx, two;
  event_t r0, r1, cur;
  logic   taken, last_taken;

  assign cur        = idx ? r1 : r0;
  assign taken      = pvalid && events.ready;
  assign last_taken = taken && (idx || !two);
  assign free       = !pvalid || last_taken;

  assign events.valid     = pvalid;
  assign events.gesture   = cur.gesture;
  assign events.at_x      = cur.at_x;
  assign events.at_y      = cur.at_y;
  assign events.final_res = idx || !two;

  always_ff @(posedge clk) begin
    if (rst) begin
      pvalid <= 1'b0;
      idx    <= 1'b0;
    end else if (load) begin
      pvalid <= pair.any;
      idx    <= 1'b0;
    end else if (last_taken) begin
      pvalid <= 1'b0;
      idx    <= 1'b0;
    end else if (taken) begin
      idx <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      two <= pair.two;
      r0  <= pair.r0;
      r1  <= pair.r1;
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst) load |-> free)
    else $error("result buffer overwritten before drained");
  a_second_beat: assert property (@(posedge clk) disable iff (rst)
    (events.valid && events.ready && !events.final_res) |=>
      (events.valid && events.final_res))
    else $error("second result of an item lost");
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (events.valid && events.ready && events.final_res && !(load && pair.any)) |=>
      !events.valid)
    else $error("result repeated after final beat");
  a_idx_two: assert property (@(posedge clk) disable iff (rst)
    (pvalid && idx) |-> two)
    else $error("second slot shown for a single result");

endmodule

FILE: hw/rtl/pointer_gesture_recognizer_core.sv
// Top level of the pointer gesture recognizer: input register, config,
// step engine and result buffer. Depends on pgr_pkg, pgr_item_if,
// pgr_event_if, pgr_cfg, pgr_engine, pgr_out.
//
//  channel  | dir | handshake     | beat
//  ---------+-----+---------------+------------------------------------
//  items    | in  | valid/ready   | op, pos_x, pos_y, tick_amount
//  events   | out | valid/ready   | gesture, at_x, at_y, final_res
//  cfg      | in  | cfg_we only   | cfg_index, cfg_data
//
// An item is registered, then stepped by the engine into the result buffer,
// from which its first event is sent.
// Throughput, while events is ready: one item per cycle when it yields at
// most one event; a two-event item sends one beat per cycle, next item waits.
// A stalled events channel holds the buffer; one item waits in the input
// register and ready drops until the buffer drains.
// rst is synchronous; it restores the default config and clears all state but the buffered event data.
module pointer_gesture_recognizer_core import pgr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  pgr_item_if.sink             items,
  pgr_event_if.source          events,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  cfg_data_t            cfg_data
);

  cfg_t      cfg;
  item_t     stage_item;
  logic      stage_valid;
  logic      free, fire;
  res_pair_t pair;

  assign fire        = stage_valid && free;
  assign items.ready = !stage_valid || free;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (items.valid && items.ready) begin
      stage_valid <= 1'b1;
    end else if (fire) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_item <= '0;
    end else if (items.valid && items.ready) begin
      stage_item <= '{items.op, items.pos_x, items.pos_y, items.tick_amount};
    end
  end

  pgr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pgr_engine u_engine (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (stage_item),
    .cfg  (cfg),
    .pair (pair)
  );

  pgr_out u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (fire),
    .pair   (pair),
    .free   (free),
    .events (events)
  );

  a_hold_item: assert property (@(posedge clk) disable iff (rst)
    (stage_valid && !fire) |=> (stage_valid && $stable(stage_item)))
    else $error("waiting item lost or changed");
  a_no_accept_blocked: assert property (@(posedge clk) disable iff (rst)
    (stage_valid && !free) |-> !items.ready)
    else $error("item accepted over a blocked stage");
  a_fire_emits: assert property (@(posedge clk) disable iff (rst)
    (fire && pair.any) |=> events.valid)
    else $error("stepped item produced no visible event");

endmodule
